/* rtl/prtt_pkg.sv */
package prtt_pkg;

    // Request kinds as they arrive on the input queue
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_CHK  = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NONE    = 2'd1,
        ST_FULL    = 2'd2,
        ST_EXPIRED = 2'd3
    } stat_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd8;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] seq;
    } key_t;

    typedef struct packed {
        op_t  op;
        key_t key;
    } cmd_t;

    typedef struct packed {
        stat_t status;
        key_t  key;
    } res_t;

    // Handshake between two internal stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

/* rtl/prtt_front.sv */
// Front end: takes input beats, decodes the kind, queues commands (2 deep).
module prtt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          kind,
    input  logic [31:0]         ip_addr,
    input  logic [15:0]         peer_port,
    input  logic [15:0]         seq_no,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output prtt_pkg::cmd_t      cmd
);

    prtt_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    prtt_pkg::cmd_t new_cmd;
    logic           do_push;
    logic           do_pop;

    // Keys only matter for add and delete; drop them otherwise
    always_comb
    begin
        new_cmd.op  = prtt_pkg::op_t'(kind);
        new_cmd.key = '{addr: ip_addr, port: peer_port, seq: seq_no};
        unique case (new_cmd.op)
            prtt_pkg::OP_ADD, prtt_pkg::OP_DEL: ;
            default: new_cmd.key = '0;
        endcase
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = cmd_valid & cmd_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/prtt_engine.sv */
// Back end: entry memory kept in order of addition (slot 0 oldest).
// Scans newest to oldest, then closes the gap by moving later entries down.
module prtt_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  prtt_pkg::cmd_t cmd,
    input  logic [31:0]    timeout,
    output prtt_pkg::hs_t  res_hs_o,
    input  logic           res_ready,
    output prtt_pkg::res_t res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    typedef struct packed {
        prtt_pkg::key_t key;
        logic [31:0]    stamp;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRD  = 6'b000010,
        S_SCMP = 6'b000100,
        S_MRD  = 6'b001000,
        S_MWR  = 6'b010000,
        S_RES  = 6'b100000
    } state_t;

    entry_t         mem [TABLE_DEPTH];
    entry_t         rd_data_reg;

    state_t         state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [31:0]    now_reg, now_next;
    prtt_pkg::cmd_t cur_reg, cur_next;
    prtt_pkg::res_t res_reg, res_next;

    logic           mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t         mem_wdata;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [31:0]    age;
    logic           hit;

    assign pos_inc = pos_reg + 1'b1;
    assign cnt_dec = cnt_reg - 1'b1;
    assign age     = now_reg - rd_data_reg.stamp;
    assign hit     = (cur_reg.op == prtt_pkg::OP_DEL) ? (rd_data_reg.key == cur_reg.key)
                                                      : (age > timeout);

    assign cmd_ready      = (state_reg == S_IDLE);
    assign res_hs_o.valid = (state_reg == S_RES);
    assign res_hs_o.ready = res_ready;
    assign res            = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        now_next   = now_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[IDX_W-1:0];
        mem_wdata  = '{key: cmd.key, stamp: now_reg};
        mem_raddr  = pos_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    res_next = '{status: prtt_pkg::ST_DONE, key: '0};
                    unique case (cmd.op)
                        prtt_pkg::OP_ADD:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                res_next.status = prtt_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            state_next = S_RES;
                        end
                        prtt_pkg::OP_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            state_next = S_RES;
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = prtt_pkg::ST_NONE;
                                state_next      = S_RES;
                            end
                            else
                            begin
                                pos_next   = cnt_dec;
                                state_next = S_SRD;
                            end
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (hit)
                begin
                    if (cur_reg.op == prtt_pkg::OP_CHK)
                    begin
                        res_next.status = prtt_pkg::ST_EXPIRED;
                        res_next.key    = rd_data_reg.key;
                    end
                    if (pos_inc == cnt_reg)
                    begin
                        cnt_next   = cnt_dec;
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
                else if (pos_reg == '0)
                begin
                    res_next.status = prtt_pkg::ST_NONE;
                    state_next      = S_RES;
                end
                else
                begin
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                mem_raddr  = pos_inc[IDX_W-1:0];
                state_next = S_MWR;
            end
            S_MWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                pos_next  = pos_inc;
                if (pos_inc == cnt_dec)
                begin
                    cnt_next   = cnt_dec;
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_MRD;
                end
            end
            S_RES:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            now_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            now_reg   <= now_next;
        end
    end

endmodule

/* rtl/prtt_out_q.sv */
// Result queue, 2 deep; keeps the engine free while a result waits.
module prtt_out_q (
    input  logic           clk,
    input  logic           rst_n,
    input  prtt_pkg::hs_t  res_hs_i,
    input  prtt_pkg::res_t res,
    output logic           res_ready,
    output logic           empty,
    input  logic           pop,
    output prtt_pkg::res_t head
);

    prtt_pkg::res_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           do_push;
    logic           do_pop;

    assign res_ready = (fill_reg != 2'd2);
    assign empty     = (fill_reg == 2'd0);
    assign head      = q_reg[rd_ptr_reg];
    assign do_push   = res_hs_i.valid & res_hs_i.ready & res_ready;
    assign do_pop    = pop & ~empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/pending_request_timeout_table_core.sv */
// Channel   Handshake              Beat contents
// --------  ---------------------  ----------------------------------------
// request   push / full            kind, ip_addr, peer_port, seq_no
// result    pop / empty            status, out_ip_addr, out_port, out_seq_no
// config    cfg_valid / cfg_ready  cfg_data = timeout in seconds
//
// Add and tick go from idle straight to the result state. Delete and timeout
// check read and compare each entry scanned (newest first), then read and
// write each later entry to move it down and close the gap; the single read
// port of the entry memory sets this. Reset empties the table at once (fill
// count), clears the seconds counter and loads a timeout of 8; no clearing
// pass. Two-deep queues on each side let both sides stall independently.
module pending_request_timeout_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [31:0] ip_addr,
    input  logic [15:0] peer_port,
    input  logic [15:0] seq_no,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [31:0] out_ip_addr,
    output logic [15:0] out_port,
    output logic [15:0] out_seq_no,
    // timeout register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0]    timeout_reg;
    logic           cmd_valid;
    logic           cmd_ready;
    prtt_pkg::cmd_t cmd;
    prtt_pkg::hs_t  res_hs;
    logic           res_ready;
    prtt_pkg::res_t res;
    prtt_pkg::res_t head;

    // Register is always writable; write it only while no request is in flight.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= prtt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    prtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .ip_addr   (ip_addr),
        .peer_port (peer_port),
        .seq_no    (seq_no),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    prtt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .timeout   (timeout_reg),
        .res_hs_o  (res_hs),
        .res_ready (res_ready),
        .res       (res)
    );

    prtt_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_hs_i  (res_hs),
        .res       (res),
        .res_ready (res_ready),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    // Fields other than status are zero unless an expired entry is returned.
    assign status      = head.status;
    assign out_ip_addr = head.key.addr;
    assign out_port    = head.key.port;
    assign out_seq_no  = head.key.seq;

endmodule
